/* rtl/dedl_pkg.sv */
`default_nettype none

package dedl_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    // Default list depth
    localparam int DEPTH_DEFAULT = 16;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [ST_W-1:0] st_t;
    typedef logic [1:0]      rsel_t;

    // Operation codes
    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_BACK  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_DELETE     = 3'd4;
    localparam op_t OP_DUMP       = 3'd5;

    // Result status codes
    localparam st_t ST_OK     = 2'd0;
    localparam st_t ST_EMPTY  = 2'd1;
    localparam st_t ST_FULL   = 2'd2;
    localparam st_t ST_BADPOS = 2'd3;

    // Where the first read of an operation lands in the list
    localparam rsel_t RS_FRONT  = 2'd0;
    localparam rsel_t RS_BACK   = 2'd1;
    localparam rsel_t RS_DELETE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  load_in;
        logic  push_front;
        logic  push_back;
        logic  set_result;
        st_t   result_status;
        logic  start_read;
        rsel_t read_sel;
        logic  capture;
        logic  pop_head;
        logic  shift_step;
        logic  out_load;
        logic  out_dump;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic is_empty;
        logic is_full;
        logic pos_bad;
        logic remain_zero;
        logic shift_pend;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/dedl_ram.sv */
`default_nettype none

module dedl_ram
    import dedl_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/dedl_ctrl.sv */
`default_nettype none

module dedl_ctrl
    import dedl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire sts_t sts,
    output logic      busy,
    output cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;
    localparam logic [2:0] S_DUMP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.set_result = 1'b1;
                state_next     = S_RESULT;
                unique case (sts.op) inside
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                    begin
                        if (sts.is_full)
                        begin
                            cmd.result_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.result_status = ST_OK;
                            cmd.push_front    = (sts.op == OP_PUSH_FRONT);
                            cmd.push_back     = (sts.op == OP_PUSH_BACK);
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK, OP_DELETE:
                    begin
                        if (sts.is_empty)
                        begin
                            cmd.result_status = ST_EMPTY;
                        end
                        else if (sts.op == OP_DELETE && sts.pos_bad)
                        begin
                            cmd.result_status = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.set_result = 1'b0;
                            cmd.start_read = 1'b1;
                            cmd.read_sel   = (sts.op == OP_POP_FRONT) ? RS_FRONT :
                                             (sts.op == OP_POP_BACK)  ? RS_BACK  : RS_DELETE;
                            state_next     = S_FETCH;
                        end
                    end
                    OP_DUMP:
                    begin
                        if (sts.is_empty)
                        begin
                            cmd.result_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.set_result = 1'b0;
                            cmd.start_read = 1'b1;
                            cmd.read_sel   = RS_FRONT;
                            state_next     = S_DUMP;
                        end
                    end
                    default:
                    begin
                        cmd.result_status = ST_OK;
                    end
                endcase
            end
            S_FETCH:
            begin
                cmd.capture  = 1'b1;
                cmd.pop_head = (sts.op == OP_POP_FRONT);
                state_next   = (sts.op == OP_DELETE) ? S_SHIFT : S_RESULT;
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (sts.remain_zero && !sts.shift_pend)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_dump = 1'b1;
                    if (sts.remain_zero)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/dedl_dp.sv */
`default_nettype none

module dedl_dp
    import dedl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cmd_t                       cmd,
    output sts_t                            sts,
    input  wire op_t                        op,
    input  wire logic signed [DATA_W-1:0]   value,
    input  wire logic [$clog2(DEPTH+1)-1:0] position,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output st_t                             status,
    output logic signed [DATA_W-1:0]        data_out,
    output logic [$clog2(DEPTH+1)-1:0]      occupancy,
    output logic                            last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
    endfunction

    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    op_t               op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CW-1:0]     pos_reg;
    logic [AW-1:0]     rd_slot_reg;
    logic [AW-1:0]     wr_slot_reg;
    logic [CW-1:0]     remain_reg;
    logic              pend_reg;
    st_t               res_status_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic              out_valid_reg;
    st_t               out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [CW-1:0]     out_occ_reg;
    logic              out_last_reg;

    logic [CW-1:0]     offset;
    logic [SW-1:0]     slot_sum;
    logic [AW-1:0]     slot;
    logic              remain_zero;
    logic              out_free;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    // Ring slot of a list offset counted from the front.
    always_comb
    begin
        if (cmd.push_back)
        begin
            offset = count_reg;
        end
        else
        begin
            case (cmd.read_sel)
                RS_BACK:   offset = count_reg - 1'b1;
                RS_DELETE: offset = pos_reg - 1'b1;
                default:   offset = '0;
            endcase
        end
        slot_sum = SW'(head_reg) + SW'(offset);
        if (slot_sum >= SW'(DEPTH))
        begin
            slot_sum = slot_sum - SW'(DEPTH);
        end
        slot = slot_sum[AW-1:0];
    end

    assign remain_zero = (remain_reg == '0);
    assign out_free    = !out_valid_reg || !out_stall;

    assign ram_wr_en   = cmd.push_front || cmd.push_back || (cmd.shift_step && pend_reg);
    assign ram_wr_addr = cmd.push_front ? wrap_dec(head_reg) :
                         cmd.push_back  ? slot : wr_slot_reg;
    assign ram_wr_data = (cmd.push_front || cmd.push_back) ? value_reg : ram_rd_data;
    assign ram_rd_en   = cmd.start_read ||
                         ((cmd.shift_step || cmd.out_dump) && !remain_zero);
    assign ram_rd_addr = cmd.start_read ? slot : rd_slot_reg;

    dedl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // List state and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push_front)
            begin
                head_reg <= wrap_dec(head_reg);
            end
            else if (cmd.capture && cmd.pop_head)
            begin
                head_reg <= wrap_inc(head_reg);
            end

            if (cmd.push_front || cmd.push_back)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.capture)
            begin
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.start_read)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.shift_step)
            begin
                pend_reg <= !remain_zero;
            end

            if (cmd.out_load || cmd.out_dump)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operand, pointer and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= op;
            value_reg <= value;
            pos_reg   <= position;
        end

        if (cmd.set_result)
        begin
            res_status_reg <= cmd.result_status;
            res_data_reg   <= '0;
        end
        else if (cmd.start_read)
        begin
            res_status_reg <= ST_OK;
        end
        else if (cmd.capture)
        begin
            res_data_reg <= ram_rd_data;
        end

        if (cmd.start_read)
        begin
            rd_slot_reg <= wrap_inc(slot);
            wr_slot_reg <= slot;
            remain_reg  <= (cmd.read_sel == RS_DELETE) ? count_reg - pos_reg
                                                       : count_reg - 1'b1;
        end
        else if ((cmd.shift_step || cmd.out_dump) && !remain_zero)
        begin
            rd_slot_reg <= wrap_inc(rd_slot_reg);
            remain_reg  <= remain_reg - 1'b1;
        end

        if (cmd.shift_step && pend_reg)
        begin
            wr_slot_reg <= wrap_inc(wr_slot_reg);
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_occ_reg    <= count_reg;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.out_dump)
        begin
            out_status_reg <= ST_OK;
            out_data_reg   <= ram_rd_data;
            out_occ_reg    <= count_reg;
            out_last_reg   <= remain_zero;
        end
    end

    assign sts.op          = op_reg;
    assign sts.is_empty    = (count_reg == '0);
    assign sts.is_full     = (count_reg == CW'(DEPTH));
    assign sts.pos_bad     = (pos_reg == '0) || (pos_reg > count_reg);
    assign sts.remain_zero = remain_zero;
    assign sts.shift_pend  = pend_reg;
    assign sts.out_free    = out_free;

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data_out  = out_data_reg;
    assign occupancy = out_occ_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

/* rtl/double_ended_list_with_indexed_delete_core.sv */
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  op, value, position
// out      output     out_valid/ out_stall status, data_out, occupancy, last
//
// One item is taken at a time. A push, an ignored code or a refused operation goes
// from decode to its result; a pop adds a RAM fetch, a delete a fetch and a shift,
// and a dump streams its entries one per cycle while the output is not stalled.
// The delete shift moves one entry per cycle through the RAM write port.
// Reset empties the list at once; the RAM contents need no clearing pass. A stalled output
// holds the controller, and in_stall stays high until the item's last result is loaded.
module double_ended_list_with_indexed_delete_core
    import dedl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [OP_W-1:0]            op,
    input  wire logic signed [DATA_W-1:0]   value,
    input  wire logic [$clog2(DEPTH+1)-1:0] position,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [ST_W-1:0]                 status,
    output logic signed [DATA_W-1:0]        data_out,
    output logic [$clog2(DEPTH+1)-1:0]      occupancy,
    output logic                            last
);

    localparam int CW = $clog2(DEPTH + 1);

    // Commands and status between the sequencer and the list datapath.
    cmd_t cmd;
    sts_t sts;

    // The controller steps through the decode, the RAM read latency, the
    // delete shift and the dump sweep. It is busy from the cycle after an
    // item is accepted until its last result has been loaded for output.
    dedl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .busy     (in_stall),
        .cmd      (cmd)
    );

    // The datapath holds the ring pointers, the entry count, the list RAM
    // and the output register.
    dedl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (op),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_out  (data_out),
        .occupancy (occupancy),
        .last      (last)
    );

    // The list never reports more entries than it can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= CW'(DEPTH)))
        else $error("occupancy above list depth");

    // Only one item is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted while busy");

    // Any refused operation gives exactly one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> last)
        else $error("error result not marked last");

    // Only a dump of a non-empty list gives results that are not last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (status == ST_OK && occupancy != '0))
        else $error("unexpected non-final result");

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dedl_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int POS_W = $clog2(DEPTH + 1);

    // The two op codes that the block ignores.
    localparam op_t OP_SPARE_6 = 3'd6;
    localparam op_t OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 80;
    // The last items of the run go through with no idling on either side.
    localparam int CALM_TAIL = 30;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        st_t                     status;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]        occ;
        logic                    last;
    } list_result_t;

    // One row of the directed table. A row with reps above one pushes a run
    // of items, each with the value one higher than the one before. Rows
    // with fixed set carry their single expected result typed in; the rest
    // are checked against the list model below.
    typedef struct {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
        int                       reps;
        bit                       fixed;
        st_t                      f_status;
        logic signed [DATA_W-1:0] f_data;
        logic [POS_W-1:0]         f_occ;
    } dir_row_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [OP_W-1:0]           op = '0;
    logic signed [DATA_W-1:0]  value = '0;
    logic [POS_W-1:0]          position = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [ST_W-1:0]           status;
    logic signed [DATA_W-1:0]  data_out;
    logic [POS_W-1:0]          occupancy;
    logic                      last;

    double_ended_list_with_indexed_delete_core #(.DEPTH(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_out  (data_out),
        .occupancy (occupancy),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // List model. It keeps its own ring of entries, the slot of the front
    // entry and the number of live entries, exactly as the block should.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] ring_mem [DEPTH];
    int                       front_slot = 0;
    int                       live_count = 0;
    list_result_t             op_results[$];     // results of the latest item
    list_result_t             awaited_results[$]; // in order of arrival

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    int  stall_left = 0;

    function automatic int ring_slot(input int offset);
        return (front_slot + offset) % DEPTH;
    endfunction

    function automatic void add_result(input st_t st, input logic signed [DATA_W-1:0] d,
                                       input logic lst);
        list_result_t r;
        r.status = st;
        r.data = d;
        r.occ = POS_W'(live_count);
        r.last = lst;
        op_results.push_back(r);
    endfunction

    // Applies one operation to the model and leaves its results in
    // op_results. Emptiness is checked before the position of a delete.
    function automatic void apply_list_op(input op_t o, input logic signed [DATA_W-1:0] v,
                                          input logic [POS_W-1:0] p);
        int k;
        logic signed [DATA_W-1:0] taken;
        op_results.delete();
        taken = '0;
        case (o)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (live_count >= DEPTH)
                begin
                    add_result(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    if (o == OP_PUSH_FRONT)
                    begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        ring_mem[front_slot] = v;
                    end
                    else
                    begin
                        ring_mem[ring_slot(live_count)] = v;
                    end
                    live_count++;
                    add_result(ST_OK, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_DELETE:
            begin
                if (live_count == 0)
                begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end
                else if (o == OP_DELETE && (p < 1 || p > live_count))
                begin
                    add_result(ST_BADPOS, '0, 1'b1);
                end
                else
                begin
                    if (o == OP_POP_FRONT)
                    begin
                        taken = ring_mem[front_slot];
                        front_slot = (front_slot + 1) % DEPTH;
                    end
                    else if (o == OP_POP_BACK)
                    begin
                        taken = ring_mem[ring_slot(live_count - 1)];
                    end
                    else
                    begin
                        // Entries behind the deleted one close the gap.
                        taken = ring_mem[ring_slot(int'(p) - 1)];
                        for (k = int'(p) - 1; k + 1 < live_count; k++)
                            ring_mem[ring_slot(k)] = ring_mem[ring_slot(k + 1)];
                    end
                    live_count--;
                    add_result(ST_OK, taken, 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (live_count == 0)
                begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (k = 0; k < live_count; k++)
                        add_result(ST_OK, ring_mem[ring_slot(k)], k + 1 == live_count);
                end
            end
            default:
            begin
                add_result(ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Idling is switched off in quiet windows so that long stretches run at
    // full rate, and in the calm tail at the end of the run.
    function automatic bit may_idle();
        return !calm && ((cycle_count / 300) % 4 != 3);
    endfunction

    // Drives one item, waits until the block takes it, and then records what
    // it should produce. The caller is always at a rising edge here.
    task automatic send_item(input op_t o, input logic signed [DATA_W-1:0] v,
                             input logic [POS_W-1:0] p, input bit fixed,
                             input list_result_t fixed_res);
        if (may_idle() && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        value <= v;
        position <= p;
        do
            @(posedge clk);
        while (in_stall);
        apply_list_op(o, v, p);
        if (fixed)
        begin
            awaited_results.push_back(fixed_res);
        end
        else
        begin
            foreach (op_results[i])
                awaited_results.push_back(op_results[i]);
        end
    endtask

    // Pushes are biased by phase so that the list fills up and drains many
    // times; deletes mostly name a live position.
    task automatic send_random_item(input int push_pct);
        op_t o;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0] p;
        list_result_t none;
        int r;
        none = '{default: '0};
        r = $urandom_range(0, 99);
        if (r < push_pct)
        begin
            o = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                o = OP_DUMP;
            else if (r < 12)
                o = OP_SPARE_6;
            else if (r < 14)
                o = OP_SPARE_7;
            else if (r < 39)
                o = OP_POP_FRONT;
            else if (r < 64)
                o = OP_POP_BACK;
            else
                o = OP_DELETE;
        end
        case ($urandom_range(0, 11))
            0: v = '0;
            1: v = -1;
            2: v = 32'sh7FFF_FFFF;
            3: v = 32'sh8000_0000;
            default: v = $urandom;
        endcase
        if (live_count > 0 && $urandom_range(0, 9) < 8)
            p = POS_W'($urandom_range(1, live_count));
        else
            p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        send_item(o, v, p, 1'b0, none);
    endtask

    dir_row_t directed_rows[$];

    function automatic void add_row(input op_t o, input logic signed [DATA_W-1:0] v,
                                    input int p, input int reps, input int fixed,
                                    input st_t st, input logic signed [DATA_W-1:0] d,
                                    input int occ);
        dir_row_t row;
        row.op = o;
        row.value = v;
        row.pos = POS_W'(p);
        row.reps = reps;
        row.fixed = (fixed != 0);
        row.f_status = st;
        row.f_data = d;
        row.f_occ = POS_W'(occ);
        directed_rows.push_back(row);
    endfunction

    initial
    begin
        list_result_t typed;
        int push_pct;

        foreach (ring_mem[i])
            ring_mem[i] = '0;

        // Operations on an empty list, including a dump and an ignored code.
        add_row(OP_POP_FRONT, 0, 0, 1, 1, ST_EMPTY, 0, 0);
        add_row(OP_POP_BACK, 0, 0, 1, 1, ST_EMPTY, 0, 0);
        add_row(OP_DELETE, 0, 1, 1, 1, ST_EMPTY, 0, 0);
        add_row(OP_DUMP, 0, 0, 1, 1, ST_EMPTY, 0, 0);
        add_row(OP_SPARE_6, 0, 0, 1, 1, ST_OK, 0, 0);
        // Removing the only entry by every route, with the value extremes.
        add_row(OP_PUSH_BACK, 32'sh7FFF_FFFF, 0, 1, 1, ST_OK, 0, 1);
        add_row(OP_POP_FRONT, 0, 0, 1, 1, ST_OK, 32'sh7FFF_FFFF, 0);
        add_row(OP_PUSH_FRONT, 32'sh8000_0000, 0, 1, 1, ST_OK, 0, 1);
        add_row(OP_POP_BACK, 0, 0, 1, 1, ST_OK, 32'sh8000_0000, 0);
        add_row(OP_PUSH_BACK, -1, 0, 1, 1, ST_OK, 0, 1);
        add_row(OP_DELETE, 0, 1, 1, 1, ST_OK, -1, 0);
        // Bad positions on either side of a one-entry list.
        add_row(OP_PUSH_FRONT, 0, 0, 1, 1, ST_OK, 0, 1);
        add_row(OP_DELETE, 0, 0, 1, 1, ST_BADPOS, 0, 1);
        add_row(OP_DELETE, 0, 2, 1, 1, ST_BADPOS, 0, 1);
        add_row(OP_SPARE_7, 0, 0, 1, 1, ST_OK, 0, 1);
        // Fill the list, then push into a full one from both ends.
        add_row(OP_PUSH_BACK, 32'sh5A5A_0000, 0, DEPTH - 1, 0, ST_OK, 0, 0);
        add_row(OP_PUSH_FRONT, 1, 0, 1, 1, ST_FULL, 0, DEPTH);
        add_row(OP_PUSH_BACK, 2, 0, 1, 1, ST_FULL, 0, DEPTH);
        add_row(OP_DUMP, 0, 0, 1, 0, ST_OK, 0, 0);
        // Deletes at the top position, past the end, at the front and inside.
        add_row(OP_DELETE, 0, DEPTH, 1, 0, ST_OK, 0, 0);
        add_row(OP_DELETE, 0, DEPTH + 1, 1, 1, ST_BADPOS, 0, DEPTH - 1);
        add_row(OP_DELETE, 0, (1 << POS_W) - 1, 1, 1, ST_BADPOS, 0, DEPTH - 1);
        add_row(OP_DELETE, 0, 1, 1, 0, ST_OK, 0, 0);
        add_row(OP_DELETE, 0, 7, 1, 0, ST_OK, 0, 0);
        add_row(OP_PUSH_FRONT, 32'sh0123_4567, 0, 1, 0, ST_OK, 0, 0);
        add_row(OP_DUMP, 0, 0, 1, 0, ST_OK, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            typed.status = directed_rows[r].f_status;
            typed.data = directed_rows[r].f_data;
            typed.occ = directed_rows[r].f_occ;
            typed.last = 1'b1;
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_item(directed_rows[r].op, directed_rows[r].value + k, directed_rows[r].pos,
                          directed_rows[r].fixed, typed);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Let the output side drain completely once, mid-run, with the
            // input held idle.
            if (n == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (awaited_results.size() != 0);
            end
            if (n == RANDOM_ITEMS - CALM_TAIL)
                calm = 1'b1;
            case ((n / 20) % 3)
                0: push_pct = 75;
                1: push_pct = 20;
                default: push_pct = 45;
            endcase
            send_random_item(push_pct);
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Output stall in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (may_idle() && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Every result taken by the output side is matched against the oldest
    // expected one, field by field.
    always @(posedge clk)
    begin : watch_results
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected, status %0d data %0d",
                                          status, data_out));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (data_out !== want.data)
                    report_mismatch($sformatf("data_out %0d, expected %0d", data_out, want.data));
                if (occupancy !== want.occ)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              occupancy, want.occ));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule
